### sv/sgr_pkg.sv
// Shared types, constants and helpers for the stream group reverser.
`timescale 1ns / 1ps

package sgr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int VALUE_W   = 32;
   localparam int SIZE_W    = 5;

   typedef struct packed {
      logic signed [VALUE_W-1:0] elem_value;
      logic                      list_end;
   } sgr_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      burst_end;
      logic                      list_done;
   } sgr_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic load;
   } sgr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic group_flush;
      logic drain_last;
      logic rsp_free;
   } sgr_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } sgr_state_type;

   // Clamp the programmed group size into 1..MAX_GROUP.
   function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] g);
      logic [CNT_W+SIZE_W-1:0] gw;
      gw = (CNT_W + SIZE_W)'(g);
      if (g == '0) begin
         return CNT_W'(1);
      end else if (gw > (CNT_W + SIZE_W)'(MAX_GROUP)) begin
         return CNT_W'(MAX_GROUP);
      end else begin
         return gw[CNT_W-1:0];
      end
   endfunction

endpackage

### sv/sgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sgr_ctrl.sv
// Controller state machine: accept, then drain a group one word at a time.
`timescale 1ns / 1ps

module sgr_ctrl
   import sgr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sgr_stat_type stat,
   output sgr_cmd_type  cmd
);

   sgr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && stat.group_flush) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // hold the read word until the output register frees up
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = stat.drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/sgr_datapath.sv
// Datapath: group buffer, fill counter, drain index and output register.
`timescale 1ns / 1ps

module sgr_datapath
   import sgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [SIZE_W-1:0] csr_data,
   input  sgr_req_type       req_payload,
   input  sgr_cmd_type       cmd,
   output sgr_stat_type      stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sgr_rsp_type       rsp_payload
);

   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              reverse_ff, reverse_in;
   logic              end_ff, end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sgr_rsp_type       rsp_ff, rsp_in;

   logic [CNT_W-1:0]   held;
   logic               full_group;
   logic [VALUE_W-1:0] rd_data;

   assign held       = fill_ff + CNT_W'(1);
   assign full_group = (held >= eff_size(size_ff));

   sgr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_GROUP)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_payload.elem_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      fill_in      = fill_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      reverse_in   = reverse_ff;
      end_in       = end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         if (full_group || req_payload.list_end) begin
            fill_in    = '0;
            left_in    = held;
            reverse_in = full_group;
            end_in     = req_payload.list_end;
            idx_in     = full_group ? fill_ff[ADDR_W-1:0] : '0;
         end else begin
            fill_in = held;
         end
      end

      if (cmd.load) begin
         rsp_in.out_value = rd_data;
         rsp_in.burst_end = (left_ff == CNT_W'(1));
         rsp_in.list_done = (left_ff == CNT_W'(1)) && end_ff;
         rsp_valid_in     = 1'b1;
         left_in          = left_ff - CNT_W'(1);
         idx_in           = reverse_ff ? idx_ff - ADDR_W'(1) : idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_W'(3);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            size_ff <= csr_data;
         end
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      idx_ff     <= idx_in;
      reverse_ff <= reverse_in;
      end_ff     <= end_in;
      rsp_ff     <= rsp_in;
   end

   assign stat.group_flush = full_group || req_payload.list_end;
   assign stat.drain_last  = (left_ff == CNT_W'(1));
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/stream_group_reverser_unit.sv
// Stream group reverser: buffers list words and emits each full group reversed.
//
// Channels: req_ carries one list word (value and end-of-list flag), rsp_
// carries result words, csr_ writes the group size (reset value 3; zero acts
// as 1, values above 16 act as 16). Write csr_ only while the block is idle.
// A word that completes no group and ends no list is absorbed and
// produces nothing. A word that completes a group (or ends the list)
// starts a drain: the buffered words come out reversed (in arrival order for
// a partial group at list end). For each result the controller issues a
// registered buffer read and then an output load, which waits while the
// output register is still full. The last result of each drain carries
// burst_end, and the final word of the list also carries list_done.
// req_ready stays low during a drain; a stalled receiver holds the drain in
// place, and the output register keeps its word until taken. Reset is
// synchronous: it empties the buffer count, drops rsp_valid and restores
// the group size.
`timescale 1ns / 1ps

module stream_group_reverser_unit
   import sgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  sgr_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sgr_rsp_type       rsp_payload
);

   sgr_cmd_type  cmd;
   sgr_stat_type stat;

   assign csr_ready = 1'b1;

   sgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sgr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // never overwrite a result the receiver has not taken
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> stat.rsp_free)
      else $error("result loaded over a pending word");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> !req_ready && rsp_valid == $past(rsp_valid && !rsp_ready) || cmd.load
         || !req_ready)
      else $error("input taken while a buffer read is in flight");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load && stat.drain_last |=> req_ready)
      else $error("block did not return to accepting after the last word");

   a_absorb: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !stat.group_flush |=> req_ready && !cmd.load)
      else $error("buffered word started a drain");

endmodule
